// ----- rtl/nnis_pkg.sv -----
// Shared constants, types and codes of the nearest-neighbor image scaler.
`timescale 1ns / 1ps

package nnis_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int PIXEL_BITS  = 32;

	localparam int X_BITS      = $clog2(MAX_WIDTH);
	localparam int Y_BITS      = $clog2(MAX_HEIGHT);
	localparam int ADDR_BITS   = X_BITS + Y_BITS;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	localparam int COORD_BITS  = 16;
	localparam int DIM_BITS    = 9;
	localparam int FACTOR_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int REM_BITS    = FACTOR_BITS + 1;
	localparam int PROD_BITS   = DIM_BITS + FACTOR_BITS;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = FACTOR_BITS;

	localparam int QUEUE_DEPTH = 16;
	localparam int Q_PTR_BITS  = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

	localparam int IN_DATA_BITS  = 2 * COORD_BITS + PIXEL_BITS;
	localparam int OUT_DATA_BITS = PIXEL_BITS + 2 * COORD_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_SCALE_FACTOR  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_t;

	// Clamped source size, factor and scaled size seen by both halves.
	typedef struct packed {
		logic [DIM_BITS-1:0]    width;
		logic [DIM_BITS-1:0]    height;
		logic [FACTOR_BITS-1:0] factor;
		logic [COORD_BITS-1:0]  scaled_width;
		logic [COORD_BITS-1:0]  scaled_height;
	} cfg_t;

	// One classified item on its way from front to back.
	typedef struct packed {
		logic                  fetch;
		logic                  ok;
		logic [ADDR_BITS-1:0]  addr;
		logic [PIXEL_BITS-1:0] pixel;
	} job_t;

endpackage

// ----- rtl/nnis_front.sv -----
// Front end: accepts words, classifies them and maps output coordinates to source ones.
`timescale 1ns / 1ps

module nnis_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [nnis_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input  logic                                s_tuser,
	input  nnis_pkg::cfg_t                      cfg,
	input  logic                                pop,
	output logic                                push,
	output nnis_pkg::job_t                      push_job
);

	localparam int STEPS = nnis_pkg::FRAC_BITS;

	typedef struct packed {
		logic                                fetch;
		logic                                ok;
		logic [nnis_pkg::ADDR_BITS-1:0]      waddr;
		logic [nnis_pkg::PIXEL_BITS-1:0]     pixel;
		logic [nnis_pkg::REM_BITS-1:0]       rem_x;
		logic [nnis_pkg::REM_BITS-1:0]       rem_y;
		logic [nnis_pkg::FRAC_BITS-1:0]      quo_x;
		logic [nnis_pkg::FRAC_BITS-1:0]      quo_y;
	} div_stage_t;

	// One restoring step per lane: shift in a zero bit of the scaled coordinate.
	function automatic div_stage_t div_step(input div_stage_t s,
			input logic [nnis_pkg::FACTOR_BITS-1:0] f);
		logic [nnis_pkg::REM_BITS:0] rx2;
		logic [nnis_pkg::REM_BITS:0] ry2;
		logic [nnis_pkg::REM_BITS:0] fx;
		div_stage_t r;
		r   = s;
		fx  = (nnis_pkg::REM_BITS + 1)'(f);
		rx2 = {s.rem_x, 1'b0};
		ry2 = {s.rem_y, 1'b0};
		if (rx2 >= fx) begin
			r.rem_x = nnis_pkg::REM_BITS'(rx2 - fx);
			r.quo_x = {s.quo_x[nnis_pkg::FRAC_BITS-2:0], 1'b1};
		end else begin
			r.rem_x = rx2[nnis_pkg::REM_BITS-1:0];
			r.quo_x = {s.quo_x[nnis_pkg::FRAC_BITS-2:0], 1'b0};
		end
		if (ry2 >= fx) begin
			r.rem_y = nnis_pkg::REM_BITS'(ry2 - fx);
			r.quo_y = {s.quo_y[nnis_pkg::FRAC_BITS-2:0], 1'b1};
		end else begin
			r.rem_y = ry2[nnis_pkg::REM_BITS-1:0];
			r.quo_y = {s.quo_y[nnis_pkg::FRAC_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	logic                                  accept;
	logic [nnis_pkg::Q_CNT_BITS-1:0]       credit_q;

	logic                                  vld_s1;
	logic                                  cmd_s1;
	logic [nnis_pkg::COORD_BITS-1:0]       x_s1;
	logic [nnis_pkg::COORD_BITS-1:0]       y_s1;
	logic [nnis_pkg::PIXEL_BITS-1:0]       pix_s1;

	logic [STEPS:0]                        vld_s;
	div_stage_t                            st_s [STEPS+1];
	div_stage_t                            head;

	logic                                  fetch_s1;
	logic                                  write_in_s1;
	logic                                  fetch_in_s1;
	logic                                  last_in_src;

	assign accept   = s_tvalid && s_tready;
	// Items in flight up to the queue never exceed its depth, so the pipe never stalls.
	assign s_tready = credit_q < nnis_pkg::Q_CNT_BITS'(nnis_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + nnis_pkg::Q_CNT_BITS'(accept)
				- nnis_pkg::Q_CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s  <= '0;
		end else begin
			vld_s1 <= accept;
			vld_s  <= {vld_s[STEPS-1:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= s_tuser;
			x_s1   <= s_tdata[nnis_pkg::COORD_BITS-1:0];
			y_s1   <= s_tdata[2*nnis_pkg::COORD_BITS-1:nnis_pkg::COORD_BITS];
			pix_s1 <= s_tdata[nnis_pkg::IN_DATA_BITS-1:2*nnis_pkg::COORD_BITS];
		end
	end

	assign fetch_s1    = nnis_pkg::cmd_t'(cmd_s1) == nnis_pkg::CMD_FETCH;
	assign write_in_s1 = (32'(x_s1) < nnis_pkg::MAX_WIDTH)
		&& (32'(y_s1) < nnis_pkg::MAX_HEIGHT);
	assign fetch_in_s1 = (cfg.factor != '0) && (x_s1 < cfg.scaled_width)
		&& (y_s1 < cfg.scaled_height);

	always_ff @(posedge clk) begin
		st_s[0].fetch <= fetch_s1;
		st_s[0].ok    <= fetch_s1 ? fetch_in_s1 : write_in_s1;
		st_s[0].waddr <= {nnis_pkg::Y_BITS'(y_s1), nnis_pkg::X_BITS'(x_s1)};
		st_s[0].pixel <= pix_s1;
		st_s[0].rem_x <= nnis_pkg::REM_BITS'(x_s1);
		st_s[0].rem_y <= nnis_pkg::REM_BITS'(y_s1);
		st_s[0].quo_x <= '0;
		st_s[0].quo_y <= '0;
		for (int i = 1; i <= STEPS; i++) begin
			st_s[i] <= div_step(st_s[i-1], cfg.factor);
		end
	end

	assign head        = st_s[STEPS];
	assign last_in_src = (32'(head.quo_x) < 32'(cfg.width))
		&& (32'(head.quo_y) < 32'(cfg.height));

	assign push           = vld_s[STEPS];
	assign push_job.fetch = head.fetch;
	assign push_job.ok    = head.fetch ? (head.ok && last_in_src) : head.ok;
	assign push_job.addr  = head.fetch
		? {nnis_pkg::Y_BITS'(head.quo_y), nnis_pkg::X_BITS'(head.quo_x)} : head.waddr;
	assign push_job.pixel = head.pixel;

endmodule

// ----- rtl/nnis_queue.sv -----
// Short job queue between the front end and the frame-store back end.
`timescale 1ns / 1ps

module nnis_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nnis_pkg::job_t push_job,
	input  logic           pop,
	output logic           not_empty,
	output nnis_pkg::job_t head_job
);

	nnis_pkg::job_t                     slot_q [nnis_pkg::QUEUE_DEPTH];
	logic [nnis_pkg::Q_PTR_BITS-1:0]    wr_ptr_q;
	logic [nnis_pkg::Q_PTR_BITS-1:0]    rd_ptr_q;
	logic [nnis_pkg::Q_CNT_BITS-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + nnis_pkg::Q_CNT_BITS'(push) - nnis_pkg::Q_CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	assign not_empty = count_q != '0;
	assign head_job  = slot_q[rd_ptr_q];

endmodule

// ----- rtl/nnis_back.sv -----
// Back end: frame store access and the registered result word.
`timescale 1ns / 1ps

module nnis_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 not_empty,
	input  nnis_pkg::job_t                       head_job,
	output logic                                 pop,
	input  nnis_pkg::cfg_t                       cfg,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [nnis_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	output logic                                 m_tuser
);

	logic [nnis_pkg::PIXEL_BITS-1:0] frame_mem [nnis_pkg::STORE_DEPTH];

	logic                            vld_s1;
	logic                            fetch_s1;
	logic                            ok_s1;
	logic [nnis_pkg::PIXEL_BITS-1:0] rd_s1;

	logic                            out_vld_q;
	logic                            out_ok_q;
	logic [nnis_pkg::PIXEL_BITS-1:0] out_pix_q;
	logic                            advance;

	assign advance = !out_vld_q || m_tready;
	assign pop     = not_empty && (!vld_s1 || advance);

	// Read before write on the same port; a write word returns zero anyway.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (!head_job.fetch && head_job.ok) begin
				frame_mem[head_job.addr] <= head_job.pixel;
			end
			rd_s1 <= frame_mem[head_job.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fetch_s1 <= head_job.fetch;
			ok_s1    <= head_job.ok;
		end
		if (advance && vld_s1) begin
			out_ok_q  <= ok_s1;
			out_pix_q <= (fetch_s1 && ok_s1) ? rd_s1 : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {cfg.scaled_height, cfg.scaled_width, out_pix_q};
	assign m_tuser  = out_ok_q;

endmodule

// ----- rtl/nearest_neighbor_image_scaler.sv -----
// Top level of the nearest-neighbor image scaler: config registers, front, queue, back.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: coord_x, coord_y, pixel_in; tuser: command
//  m_*      out  m_tvalid/m_tready  tdata: pixel_out, scaled_width, scaled_height;
//                                   tuser: inside_res
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word per cycle in and out when the sink keeps m_tready high.
// On the way from acceptance to m_tvalid the input register loads at the accepting edge,
// then classify, 8 divide steps, queue, store read and output follow in that order.
// The divide by scale_factor makes the pipe long; the single-port frame store sets the rate.
// Reset clears control only; the frame store holds garbage until written.
// A stalled output holds the back end; the front accepts until words in flight fill the queue.
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [15:0] coord_x, [31:16] coord_y, [63:32] pixel_in
	input  logic [nnis_pkg::IN_DATA_BITS-1:0]     s_tdata,
	// [0] command
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [31:0] pixel_out, [47:32] scaled_width, [63:48] scaled_height
	output logic [nnis_pkg::OUT_DATA_BITS-1:0]    m_tdata,
	// [0] inside_res
	output logic                                  m_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [nnis_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [nnis_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	logic [nnis_pkg::DIM_BITS-1:0]    src_w_q;
	logic [nnis_pkg::DIM_BITS-1:0]    src_h_q;
	logic [nnis_pkg::FACTOR_BITS-1:0] factor_q;
	logic [nnis_pkg::DIM_BITS-1:0]    clamp_w;
	logic [nnis_pkg::DIM_BITS-1:0]    clamp_h;
	logic [nnis_pkg::PROD_BITS-1:0]   prod_w;
	logic [nnis_pkg::PROD_BITS-1:0]   prod_h;
	logic [nnis_pkg::COORD_BITS-1:0]  scaled_w_q;
	logic [nnis_pkg::COORD_BITS-1:0]  scaled_h_q;
	logic [nnis_pkg::DIM_BITS-1:0]    width_q;
	logic [nnis_pkg::DIM_BITS-1:0]    height_q;
	nnis_pkg::cfg_t                   cfg;

	logic                             push;
	logic                             pop;
	logic                             not_empty;
	nnis_pkg::job_t                   push_job;
	nnis_pkg::job_t                   head_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= nnis_pkg::DIM_BITS'(256);
			src_h_q  <= nnis_pkg::DIM_BITS'(256);
			factor_q <= nnis_pkg::FACTOR_BITS'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nnis_pkg::REG_SOURCE_WIDTH: begin
					src_w_q <= cfg_data[nnis_pkg::DIM_BITS-1:0];
				end
				nnis_pkg::REG_SOURCE_HEIGHT: begin
					src_h_q <= cfg_data[nnis_pkg::DIM_BITS-1:0];
				end
				nnis_pkg::REG_SCALE_FACTOR: begin
					factor_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign clamp_w = (32'(src_w_q) > nnis_pkg::MAX_WIDTH)
		? nnis_pkg::DIM_BITS'(nnis_pkg::MAX_WIDTH) : src_w_q;
	assign clamp_h = (32'(src_h_q) > nnis_pkg::MAX_HEIGHT)
		? nnis_pkg::DIM_BITS'(nnis_pkg::MAX_HEIGHT) : src_h_q;
	assign prod_w  = nnis_pkg::PROD_BITS'(clamp_w) * nnis_pkg::PROD_BITS'(factor_q);
	assign prod_h  = nnis_pkg::PROD_BITS'(clamp_h) * nnis_pkg::PROD_BITS'(factor_q);

	// Saturate the scaled size at the coordinate range; also register the clamped source size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scaled_w_q <= nnis_pkg::COORD_BITS'(256);
			scaled_h_q <= nnis_pkg::COORD_BITS'(256);
			width_q    <= nnis_pkg::DIM_BITS'(256);
			height_q   <= nnis_pkg::DIM_BITS'(256);
		end else begin
			width_q    <= clamp_w;
			height_q   <= clamp_h;
			scaled_w_q <= (prod_w[nnis_pkg::PROD_BITS-1:nnis_pkg::FRAC_BITS+nnis_pkg::COORD_BITS]
				!= '0) ? '1
				: prod_w[nnis_pkg::FRAC_BITS+nnis_pkg::COORD_BITS-1:nnis_pkg::FRAC_BITS];
			scaled_h_q <= (prod_h[nnis_pkg::PROD_BITS-1:nnis_pkg::FRAC_BITS+nnis_pkg::COORD_BITS]
				!= '0) ? '1
				: prod_h[nnis_pkg::FRAC_BITS+nnis_pkg::COORD_BITS-1:nnis_pkg::FRAC_BITS];
		end
	end

	assign cfg.width         = width_q;
	assign cfg.height        = height_q;
	assign cfg.factor        = factor_q;
	assign cfg.scaled_width  = scaled_w_q;
	assign cfg.scaled_height = scaled_h_q;

	nnis_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg),
		.pop      (pop),
		.push     (push),
		.push_job (push_job)
	);

	nnis_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.not_empty (not_empty),
		.head_job  (head_job)
	);

	nnis_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head_job  (head_job),
		.pop       (pop),
		.cfg       (cfg),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ----- tb/sv/scaler_checker.sv -----
// Watches the scaler channels, predicts every output word and counts mismatches.
`timescale 1ns / 1ps

module scaler_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	// [15:0] coord_x, [31:16] coord_y, [63:32] pixel_in
	input  logic [nnis_pkg::IN_DATA_BITS-1:0]     s_tdata,
	// [0] command
	input  logic                                  s_tuser,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [31:0] pixel_out, [47:32] scaled_width, [63:48] scaled_height
	input  logic [nnis_pkg::OUT_DATA_BITS-1:0]    m_tdata,
	// [0] inside_res
	input  logic                                  m_tuser,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [nnis_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [nnis_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output int                                    mismatches,
	output int                                    outstanding
);

	import nnis_pkg::*;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic                  in_bounds;
		logic [COORD_BITS-1:0] width;
		logic [COORD_BITS-1:0] height;
	} scaled_word_t;

	logic [PIXEL_BITS-1:0]  frame_copy [STORE_DEPTH];
	logic [DIM_BITS-1:0]    src_w;
	logic [DIM_BITS-1:0]    src_h;
	logic [FACTOR_BITS-1:0] factor;
	scaled_word_t           expected_words [$];
	int                     errors;

	assign mismatches = errors;

	// floor(dim * factor / 256), saturated to the coordinate range
	function automatic int unsigned scaled_size(int unsigned dim);
		longint unsigned prod;
		prod = (longint'(dim) * longint'(factor)) >> FRAC_BITS;
		return (prod > 65535) ? 65535 : int'(prod);
	endfunction

	// Apply one input word to the shadow frame and return the word it must produce.
	function automatic scaled_word_t sample_pixel(cmd_t cmd, logic [COORD_BITS-1:0] x,
			logic [COORD_BITS-1:0] y, logic [PIXEL_BITS-1:0] pin);
		int unsigned  w;
		int unsigned  h;
		int unsigned  sw;
		int unsigned  sh;
		int unsigned  sx;
		int unsigned  sy;
		scaled_word_t r;
		w = (32'(src_w) > MAX_WIDTH) ? MAX_WIDTH : 32'(src_w);
		h = (32'(src_h) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(src_h);
		sw = scaled_size(w);
		sh = scaled_size(h);
		r = '0;
		r.width = sw[COORD_BITS-1:0];
		r.height = sh[COORD_BITS-1:0];
		if (cmd == CMD_WRITE) begin
			if (x < MAX_WIDTH && y < MAX_HEIGHT) begin
				frame_copy[int'(y) * MAX_WIDTH + int'(x)] = pin;
				r.in_bounds = 1'b1;
			end
		end else if (factor != 0 && x < sw && y < sh) begin
			sx = (int'(x) << FRAC_BITS) / int'(factor);
			sy = (int'(y) << FRAC_BITS) / int'(factor);
			if (sx < w && sy < h) begin
				r.pixel = frame_copy[sy * MAX_WIDTH + sx];
				r.in_bounds = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scaled_word_t got;
		scaled_word_t want;
		if (!arst_n) begin
			src_w = 9'd256;
			src_h = 9'd256;
			factor = 16'd256;
			errors = 0;
			expected_words.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_SOURCE_WIDTH:  src_w = cfg_data[DIM_BITS-1:0];
					REG_SOURCE_HEIGHT: src_h = cfg_data[DIM_BITS-1:0];
					REG_SCALE_FACTOR:  factor = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.pixel = m_tdata[31:0];
				got.width = m_tdata[47:32];
				got.height = m_tdata[63:48];
				got.in_bounds = m_tuser;
				if (expected_words.size() == 0) begin
					if (errors < 10)
						$display("unexpected word: pixel %h ok %b size %0d x %0d",
							got.pixel, got.in_bounds, got.width, got.height);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got.pixel !== want.pixel || got.in_bounds !== want.in_bounds ||
							got.width !== want.width || got.height !== want.height) begin
						if (errors < 10)
							$display({"mismatch: expected pixel %h ok %b size %0d x %0d,",
								" got pixel %h ok %b size %0d x %0d"},
								want.pixel, want.in_bounds, want.width, want.height,
								got.pixel, got.in_bounds, got.width, got.height);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_words.insert(expected_words.size(),
					sample_pixel(cmd_t'(s_tuser), s_tdata[15:0],
					s_tdata[31:16], s_tdata[63:32]));
			outstanding <= expected_words.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// Stimulus, clock, reset and verdict for the nearest-neighbor image scaler.
`timescale 1ns / 1ps

module tb_top;

	import nnis_pkg::*;

	localparam int IDLE_PCT     = 37;
	localparam int PHASES       = 16;
	localparam int PHASE_ITEMS  = 84;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [IN_DATA_BITS-1:0]   s_tdata;
	logic                      s_tuser;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0]  m_tdata;
	logic                      m_tuser;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	int                        mismatches;
	int                        outstanding;
	int                        cycles = 0;
	bit                        quiet = 1'b0;
	bit                        written [STORE_DEPTH];
	logic [DIM_BITS-1:0]       cur_w = 9'd256;
	logic [DIM_BITS-1:0]       cur_h = 9'd256;
	logic [FACTOR_BITS-1:0]    cur_f = 16'd256;

	nearest_neighbor_image_scaler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	scaler_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("nearest_neighbor_image_scaler test failed");
			$finish;
		end
	end

	function automatic int unsigned scaled_of(int unsigned dim);
		longint unsigned prod;
		prod = (longint'(dim) * longint'(cur_f)) >> FRAC_BITS;
		return (prod > 65535) ? 65535 : int'(prod);
	endfunction

	function automatic int unsigned clamp_w();
		return (32'(cur_w) > MAX_WIDTH) ? MAX_WIDTH : 32'(cur_w);
	endfunction

	function automatic int unsigned clamp_h();
		return (32'(cur_h) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(cur_h);
	endfunction

	// Tell whether a fetch at (x, y) reads the frame store, and at which entry.
	function automatic bit fetch_reads(int unsigned x, int unsigned y, output int addr);
		int unsigned sx;
		int unsigned sy;
		addr = 0;
		if (cur_f == 0 || x >= scaled_of(clamp_w()) || y >= scaled_of(clamp_h()))
			return 1'b0;
		sx = (x << FRAC_BITS) / cur_f;
		sy = (y << FRAC_BITS) / cur_f;
		if (sx >= clamp_w() || sy >= clamp_h())
			return 1'b0;
		addr = sy * MAX_WIDTH + sx;
		return 1'b1;
	endfunction

	task automatic push_word(cmd_t cmd, logic [15:0] x, logic [15:0] y, logic [31:0] pix);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {pix, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (cmd == CMD_WRITE && x < MAX_WIDTH && y < MAX_HEIGHT)
			written[int'(y) * MAX_WIDTH + int'(x)] = 1'b1;
	endtask

	// Load the sampled entry first if it was never written.
	task automatic fetch_pixel(logic [15:0] x, logic [15:0] y);
		int addr;
		if (fetch_reads(32'(x), 32'(y), addr) && !written[addr])
			push_word(CMD_WRITE, 16'(addr % MAX_WIDTH), 16'(addr / MAX_WIDTH), $urandom);
		push_word(CMD_FETCH, x, y, $urandom);
	endtask

	task automatic random_word();
		int          roll;
		int unsigned lim_w;
		int unsigned lim_h;
		int unsigned sw;
		int unsigned sh;
		roll = $urandom_range(99);
		lim_w = (clamp_w() == 0) ? MAX_WIDTH : clamp_w();
		lim_h = (clamp_h() == 0) ? MAX_HEIGHT : clamp_h();
		sw = scaled_of(clamp_w());
		sh = scaled_of(clamp_h());
		if (roll < 35)
			push_word(CMD_WRITE, 16'($urandom_range(lim_w - 1)),
				16'($urandom_range(lim_h - 1)), $urandom);
		else if (roll < 45)
			push_word(CMD_WRITE, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
				$urandom);
		else if (roll < 90 && sw > 0 && sh > 0)
			fetch_pixel(16'($urandom_range(sw)), 16'($urandom_range(sh)));
		else
			fetch_pixel(16'($urandom_range(65535)), 16'($urandom_range(65535)));
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] f);
		write_reg(REG_SOURCE_WIDTH, w);
		write_reg(REG_SOURCE_HEIGHT, h);
		write_reg(REG_SCALE_FACTOR, f);
		cfg_valid <= 1'b0;
		cur_w = w[DIM_BITS-1:0];
		cur_h = h[DIM_BITS-1:0];
		cur_f = f;
	endtask

	// Drop valid and wait until every word in flight has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] random_dim();
		logic [15:0] d;
		d = ($urandom_range(9) == 0) ? 16'($urandom_range(511)) : 16'($urandom_range(1, 16));
		if ($urandom_range(3) == 0)
			d[15:9] = 7'($urandom_range(127));
		return d;
	endfunction

	initial begin
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] f;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		cfg_valid = 1'b0;
		cfg_index = REG_SOURCE_WIDTH;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners of the store and of the coordinate range at reset settings
		push_word(CMD_WRITE, 16'd0, 16'd0, 32'h0000_0000);
		push_word(CMD_WRITE, 16'd255, 16'd255, 32'hFFFF_FFFF);
		push_word(CMD_WRITE, 16'd255, 16'd0, 32'hA5A5_A5A5);
		push_word(CMD_WRITE, 16'd0, 16'd255, 32'h5A5A_5A5A);
		push_word(CMD_WRITE, 16'd256, 16'd0, 32'h1234_5678);
		push_word(CMD_WRITE, 16'd0, 16'd256, 32'h8765_4321);
		push_word(CMD_WRITE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		push_word(CMD_WRITE, 16'h8000, 16'h7FFF, 32'h0F0F_0F0F);
		fetch_pixel(16'd0, 16'd0);
		fetch_pixel(16'd255, 16'd255);
		fetch_pixel(16'd255, 16'd0);
		fetch_pixel(16'd0, 16'd255);
		fetch_pixel(16'd256, 16'd0);
		fetch_pixel(16'd0, 16'd256);
		fetch_pixel(16'hFFFF, 16'hFFFF);
		fetch_pixel(16'h5555, 16'h00AA);
		fetch_pixel(16'd128, 16'd64);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:  begin w = 16'd4;    h = 16'd3;   f = 16'd256;   end
				1:  begin w = 16'd5;    h = 16'd7;   f = 16'd640;   end
				2:  begin w = 16'd256;  h = 16'd256; f = 16'hFFFF;  end
				3:  begin w = 16'd0;    h = 16'd6;   f = 16'd256;   end
				4:  begin w = 16'd8;    h = 16'd0;   f = 16'd512;   end
				5:  begin w = 16'd300;  h = 16'd511; f = 16'd128;   end
				6:  begin w = 16'd6;    h = 16'd5;   f = 16'd0;     end
				7:  begin w = 16'd1;    h = 16'd1;   f = 16'd1;     end
				8:  begin w = 16'd256;  h = 16'd256; f = 16'd256;   end
				9:  begin w = 16'hFE03; h = 16'd9;   f = 16'd300;   end
				default: begin
					w = random_dim();
					h = random_dim();
					f = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
						: 16'($urandom_range(64, 1024));
				end
			endcase
			drain();
			configure(w, h, f);
			// hold both sides busy through two whole phases
			quiet = (p == 10 || p == 11);
			repeat (PHASE_ITEMS) random_word();
		end

		quiet = 1'b0;
		drain();
		if (mismatches == 0)
			$display("nearest_neighbor_image_scaler test passed");
		else
			$display("nearest_neighbor_image_scaler test failed");
		$finish;
	end

endmodule
